// ----- src/obbct_pkg.sv -----
`default_nettype none

package obbct_pkg;

	// Fixed width of the pair index field
	localparam int PAIR_INDEX_WIDTH = 12;

	// Edge axes tested: two per box
	localparam int NUM_AXES = 4;

	// Distinct entries of the symmetric 4x4 Gram matrix of the edge axes
	localparam int GRAM_N = 10;
	localparam int GRAM_I [GRAM_N] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
	localparam int GRAM_J [GRAM_N] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
	localparam int GRAM_SLOT [NUM_AXES][NUM_AXES] = '{
		'{0, 1, 2, 3},
		'{1, 4, 5, 6},
		'{2, 5, 7, 8},
		'{3, 6, 8, 9}
	};

	// Fraction bits of the reciprocal used to reduce the pair index
	localparam int RECIP_SHIFT = 24;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BEGIN = 2'd1,
		EV_STAY  = 2'd2,
		EV_END   = 2'd3
	} contact_event_t;

	// Control of the contact bitmap port
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_bit;
	} ram_ctl_t;

endpackage

`default_nettype wire

// ----- src/obbct_pair_if.sv -----
`default_nettype none

interface obbct_pair_if #(
	parameter int COORD_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic [11:0]                   pair_index;
	logic                          either_dead;
	logic signed [COORD_WIDTH-1:0] left_edge_a_x;
	logic signed [COORD_WIDTH-1:0] left_edge_a_y;
	logic signed [COORD_WIDTH-1:0] left_edge_b_x;
	logic signed [COORD_WIDTH-1:0] left_edge_b_y;
	logic signed [COORD_WIDTH-1:0] right_edge_a_x;
	logic signed [COORD_WIDTH-1:0] right_edge_a_y;
	logic signed [COORD_WIDTH-1:0] right_edge_b_x;
	logic signed [COORD_WIDTH-1:0] right_edge_b_y;
	logic signed [COORD_WIDTH-1:0] centre_delta_x;
	logic signed [COORD_WIDTH-1:0] centre_delta_y;

	modport source (
		output valid, pair_index, either_dead,
		output left_edge_a_x, left_edge_a_y, left_edge_b_x, left_edge_b_y,
		output right_edge_a_x, right_edge_a_y, right_edge_b_x, right_edge_b_y,
		output centre_delta_x, centre_delta_y,
		input  ready
	);

	modport sink (
		input  valid, pair_index, either_dead,
		input  left_edge_a_x, left_edge_a_y, left_edge_b_x, left_edge_b_y,
		input  right_edge_a_x, right_edge_a_y, right_edge_b_x, right_edge_b_y,
		input  centre_delta_x, centre_delta_y,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/obbct_result_if.sv -----
`default_nettype none

interface obbct_result_if ();
	logic       valid;
	logic       ready;
	logic [1:0] contact_event;
	logic       boxes_intersect;

	modport source (
		output valid, contact_event, boxes_intersect,
		input  ready
	);

	modport sink (
		input  valid, contact_event, boxes_intersect,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/obbct_sat_pipe.sv -----
`default_nettype none

module obbct_sat_pipe import obbct_pkg::*; #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] axis_x [NUM_AXES],
	input  logic signed [W-1:0] axis_y [NUM_AXES],
	input  logic signed [W-1:0] centre_x,
	input  logic signed [W-1:0] centre_y,
	output logic                hit
);

	localparam int PW = 2 * W;

	logic signed [PW-1:0] gx_s1 [GRAM_N];
	logic signed [PW-1:0] gy_s1 [GRAM_N];
	logic signed [PW-1:0] cx_s1 [NUM_AXES];
	logic signed [PW-1:0] cy_s1 [NUM_AXES];
	logic signed [PW:0]   gd_s2 [GRAM_N];
	logic signed [PW:0]   cd_s2 [NUM_AXES];
	logic [PW-1:0]        gm_s3 [GRAM_N];
	logic [PW-1:0]        cm_s3 [NUM_AXES];
	logic [PW:0]          ha_s4 [NUM_AXES];
	logic [PW:0]          hb_s4 [NUM_AXES];
	logic [PW:0]          lhs_s4 [NUM_AXES];
	logic [PW+1:0]        rhs_s5 [NUM_AXES];
	logic [PW:0]          lhs_s5 [NUM_AXES];
	logic [NUM_AXES-1:0]  sep;
	logic                 hit_s6;

	// Products, dot sums, magnitudes, half sums, full sums, compare
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < GRAM_N; k++) begin
				gx_s1[k] <= axis_x[GRAM_I[k]] * axis_x[GRAM_J[k]];
				gy_s1[k] <= axis_y[GRAM_I[k]] * axis_y[GRAM_J[k]];
				gd_s2[k] <= gx_s1[k] + gy_s1[k];
				gm_s3[k] <= gd_s2[k][PW] ? PW'(-gd_s2[k]) : PW'(gd_s2[k]);
			end
			for (int i = 0; i < NUM_AXES; i++) begin
				cx_s1[i]  <= centre_x * axis_x[i];
				cy_s1[i]  <= centre_y * axis_y[i];
				cd_s2[i]  <= cx_s1[i] + cy_s1[i];
				cm_s3[i]  <= cd_s2[i][PW] ? PW'(-cd_s2[i]) : PW'(cd_s2[i]);
				ha_s4[i]  <= {1'b0, gm_s3[GRAM_SLOT[i][0]]} + {1'b0, gm_s3[GRAM_SLOT[i][1]]};
				hb_s4[i]  <= {1'b0, gm_s3[GRAM_SLOT[i][2]]} + {1'b0, gm_s3[GRAM_SLOT[i][3]]};
				lhs_s4[i] <= {cm_s3[i], 1'b0};
				rhs_s5[i] <= {1'b0, ha_s4[i]} + {1'b0, hb_s4[i]};
				lhs_s5[i] <= lhs_s4[i];
			end
			hit_s6 <= ~|sep;
		end
	end

	// An axis separates when twice the centre projection exceeds the spread
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			sep[i] = {1'b0, lhs_s5[i]} > rhs_s5[i];
		end
	end

	assign hit = hit_s6;

endmodule

`default_nettype wire

// ----- src/obbct_contact_ram.sv -----
`default_nettype none

module obbct_contact_ram import obbct_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ram_ctl_t      ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	output logic          rd_bit,
	output logic          busy
);

	logic          mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          busy_q;
	logic          rd_bit_q;

	// Sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_bit;
		end
		if (ctl.rd_en) begin
			rd_bit_q <= mem[rd_addr];
		end
	end

	assign rd_bit = rd_bit_q;
	assign busy   = busy_q;

endmodule

`default_nettype wire

// ----- src/obb_pair_contact_tracker.sv -----
// Channel   Role    Beat payload
// pairs     sink    pair_index, either_dead, edge vectors left a/b and right a/b, centre_delta
// results   source  contact_event, boxes_intersect
//
// One pair enters per cycle while results are taken; each result beat is
// offered from the output register once its pair has passed s1 to s6.
// The rate is set by the contact bitmap: one read and one write per cycle,
// with the last write forwarded to a read of the same pair.
// A stalled result holds the whole pipeline; pairs.ready drops in that cycle.
// After reset the bitmap is swept clear, one entry a cycle, over all
// MAX_COLLIDERS*MAX_COLLIDERS entries (4096 by default); pairs.ready stays low.
`default_nettype none

module obb_pair_contact_tracker import obbct_pkg::*; #(
	parameter int MAX_COLLIDERS = 64,
	parameter int COORD_WIDTH   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	obbct_pair_if.sink    pairs,
	obbct_result_if.source results
);

	localparam int PAIR_DEPTH = MAX_COLLIDERS * MAX_COLLIDERS;
	localparam int AW         = $clog2(PAIR_DEPTH);
	localparam int PIW        = PAIR_INDEX_WIDTH;
	// Wide enough for the raw index and for the depth itself
	localparam int XW         = ((AW > PIW) ? AW : PIW) + 1;
	localparam int RPW        = PIW + RECIP_SHIFT;
	// Rounded-up reciprocal: exact quotient for every 12-bit index
	localparam int RECIP      = (1 << RECIP_SHIFT) / PAIR_DEPTH + 1;

	logic                          advance;
	logic                          accept;
	logic                          ram_busy;
	logic                          ram_rd_bit;
	ram_ctl_t                      ram_ctl;
	logic                          hit_s6;
	logic                          prev_contact;
	contact_event_t                next_event;
	logic signed [COORD_WIDTH-1:0] axis_x [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] axis_y [NUM_AXES];
	logic [RPW-1:0]                recip_prod;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                          dead_s1, dead_s2, dead_s3, dead_s4, dead_s5, dead_s6;
	logic [PIW-1:0]                idx_s1, idx_s2;
	logic [PIW-1:0]                quo_s1;
	logic [XW-1:0]                 qd_s2;
	logic [XW-1:0]                 rem_s3;
	logic [AW-1:0]                 addr_s4, addr_s5, addr_s6;
	logic                          fwd_q;
	logic                          fwd_bit_q;
	logic                          res_valid_q;
	contact_event_t                res_event_q;
	logic                          res_hit_q;

	// The whole pipe moves together; it halts only on a result left untaken
	assign advance     = !res_valid_q || results.ready;
	assign pairs.ready = advance && !ram_busy;
	assign accept      = pairs.valid && pairs.ready;

	// Edge axes in order: left a, left b, right a, right b
	assign axis_x[0] = pairs.left_edge_a_x;
	assign axis_y[0] = pairs.left_edge_a_y;
	assign axis_x[1] = pairs.left_edge_b_x;
	assign axis_y[1] = pairs.left_edge_b_y;
	assign axis_x[2] = pairs.right_edge_a_x;
	assign axis_y[2] = pairs.right_edge_a_y;
	assign axis_x[3] = pairs.right_edge_b_x;
	assign axis_y[3] = pairs.right_edge_b_y;

	obbct_sat_pipe #(
		.W (COORD_WIDTH)
	) u_sat (
		.clk      (clk),
		.en       (advance),
		.axis_x   (axis_x),
		.axis_y   (axis_y),
		.centre_x (pairs.centre_delta_x),
		.centre_y (pairs.centre_delta_y),
		.hit      (hit_s6)
	);

	// Reduce the pair index modulo the bitmap depth: quotient by reciprocal,
	// back-multiply, subtract, then one guard correction
	assign recip_prod = RPW'(pairs.pair_index) * RPW'(RECIP);

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1  <= pairs.pair_index;
			quo_s1  <= recip_prod[RPW-1 -: PIW];
			dead_s1 <= pairs.either_dead;

			idx_s2  <= idx_s1;
			qd_s2   <= XW'(quo_s1) * XW'(PAIR_DEPTH);
			dead_s2 <= dead_s1;

			rem_s3  <= XW'(idx_s2) - qd_s2;
			dead_s3 <= dead_s2;

			addr_s4 <= (rem_s3 >= XW'(PAIR_DEPTH)) ? AW'(rem_s3 - XW'(PAIR_DEPTH))
			                                       : AW'(rem_s3);
			dead_s4 <= dead_s3;

			addr_s5 <= addr_s4;
			dead_s5 <= dead_s4;

			addr_s6 <= addr_s5;
			dead_s6 <= dead_s5;
		end
	end

	// Read the bit for the pair entering s6; write back the pair leaving it
	always_comb begin
		ram_ctl        = '0;
		ram_ctl.rd_en  = advance;
		ram_ctl.wr_en  = advance && vld_s6;
		ram_ctl.wr_bit = hit_s6;
	end

	obbct_contact_ram #(
		.DEPTH (PAIR_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ram_ctl),
		.rd_addr (addr_s5),
		.wr_addr (addr_s6),
		.rd_bit  (ram_rd_bit),
		.busy    (ram_busy)
	);

	// A read and a write of the same pair on one edge: the read sees stale
	// data, so take the written bit instead
	assign prev_contact = fwd_q ? fwd_bit_q : ram_rd_bit;

	always_comb begin
		if (hit_s6) begin
			if (dead_s6) begin
				next_event = EV_END;
			end else if (prev_contact) begin
				next_event = EV_STAY;
			end else begin
				next_event = EV_BEGIN;
			end
		end else if (prev_contact) begin
			next_event = EV_END;
		end else begin
			next_event = EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			res_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else if (advance) begin
			vld_s1      <= accept;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			res_valid_q <= vld_s6;
			fwd_q       <= vld_s6 && vld_s5 && (addr_s6 == addr_s5);
		end
	end

	// Result beat and forwarded bit: payload only
	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_bit_q   <= hit_s6;
			res_event_q <= next_event;
			res_hit_q   <= hit_s6;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.contact_event   = res_event_q;
	assign results.boxes_intersect = res_hit_q;

endmodule

`default_nettype wire

// ----- src/obbct_checker.sv -----
`default_nettype none

module obbct_checker import obbct_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_event,
	input logic       out_hit
);

	// An intersecting pair always raises begin, continue or end
	a_hit_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_hit |-> out_event != EV_NONE)
		else $error("intersecting pair reported with no event");

	// A separated pair can only end a contact or report nothing
	a_miss_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_hit |-> (out_event == EV_NONE) || (out_event == EV_END))
		else $error("separated pair reported begin or continue");

	// Stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_hit))
		else $error("result beat changed while stalled");

	// A stalled result freezes the pipeline, so no pair is taken
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("pair taken while result stalled");

	// The bitmap sweep keeps the input closed straight after reset
	a_sweep_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("pair taken before bitmap sweep");

endmodule

bind obb_pair_contact_tracker obbct_checker u_obbct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pairs.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_event (results.contact_event),
	.out_hit   (results.boxes_intersect)
);

`default_nettype wire

// ----- verif/obb_pair_contact_tracker_tb.sv -----
`default_nettype none

module obb_pair_contact_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import obbct_pkg::*;

	// Bitmap sweep of 4096 entries after reset plus about 1100 beats under heavy stalls.
	// Take it many times over.
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PIPE_DRAIN   = 16;
	localparam int PHASE_BEATS  = 370;
	localparam int POOL_SIZE    = 16;

	// One pair beat as the predictor sees it. Edges in order:
	// left a (x, y), left b (x, y), right a (x, y), right b (x, y).
	typedef struct {
		logic [11:0]        idx;
		logic               dead;
		logic signed [15:0] edge_c[8];
		logic signed [15:0] cx;
		logic signed [15:0] cy;
	} pair_beat_t;

	typedef struct {
		contact_event_t ev;
		logic           hit;
	} contact_outcome_t;

	// Directed table. Columns: pair index, dead, edge components left a x to right b y,
	// centre x, centre y, typed flag, typed event, typed intersect.
	// Rows with the typed flag clear are checked against the predictor.
	localparam int DIR_ROWS = 19;
	localparam int DIR_COLS = 15;
	localparam int PAIR_TABLE [DIR_ROWS][DIR_COLS] = '{
		// point boxes: every axis degenerate, so they always touch
		'{0,    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,          1, EV_BEGIN, 1},
		'{0,    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,          1, EV_STAY,  1},
		'{0,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,          1, EV_END,   1},
		'{0,    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,          1, EV_STAY,  1},
		// unit squares far apart: leave, then stay apart
		'{0,    0, 16, 0, 0, 16, 16, 0, 0, 16, 1000, 0,   1, EV_END,   0},
		'{0,    0, 16, 0, 0, 16, 16, 0, 0, 16, 1000, 0,   1, EV_NONE,  0},
		// exactly touching counts as overlap; one LSB further separates
		'{1,    0, 16, 0, 0, 16, 16, 0, 0, 16, 16, 0,     1, EV_BEGIN, 1},
		'{1,    0, 16, 0, 0, 16, 16, 0, 0, 16, 17, 0,     1, EV_END,   0},
		// dead and apart with a clear bit: nothing to report
		'{2,    1, 16, 0, 0, 16, 16, 0, 0, 16, 1000, 0,   1, EV_NONE,  0},
		// dead and touching sets the bit, so the next live hit continues
		'{3,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,          1, EV_END,   1},
		'{3,    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,          1, EV_STAY,  1},
		// coordinate extremes on the top index
		'{4095, 0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			32767, 32767,                                  0, EV_NONE,  0},
		'{4095, 0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			-32768, -32768,                                0, EV_NONE,  0},
		'{4095, 1, -32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768,
			-32768, 32767,                                 0, EV_NONE,  0},
		'{4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, -32768, -32768, 0, EV_NONE,  0},
		// left box a point: only the right axes can separate
		'{5,    0, 0, 0, 0, 0, 16, 0, 0, 16, 1000, 0,     1, EV_NONE,  0},
		// one zero edge on the left box; the other axes can still separate
		'{6,    0, 0, 0, 0, 16, 16, 0, 0, 16, 0, 1000,    0, EV_NONE,  0},
		'{2730, 0, 1234, -2345, 3456, -4567, -5678, 6789, 7890, -8901,
			-1111, 2222,                                   0, EV_NONE,  0},
		'{1365, 1, -21845, 21845, 10922, -10923, 21845, -21846, -10923, 10922,
			21845, -21846,                                 0, EV_NONE,  0}
	};

	logic clk;
	logic arst_n;

	obbct_pair_if #(.COORD_WIDTH(16)) pair_ch ();
	obbct_result_if                   result_ch ();

	obb_pair_contact_tracker #(
		.MAX_COLLIDERS(64),
		.COORD_WIDTH  (16)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pair_ch.sink),
		.results(result_ch.source)
	);

	// Predictor state: one contact bit per pair, cleared once at reset
	bit               contact_map [4096];
	contact_outcome_t awaited_events [$];

	// Typed expectation for the beat on the wire, set by the driver
	bit               typed_pending;
	contact_outcome_t typed_result;

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned mismatches;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random signed coordinate in [-2^scale, 2^scale - 1]
	function automatic logic signed [15:0] rand_coord(int unsigned scale);
		int unsigned span;
		span = 1 << (scale + 1);
		return 16'($urandom_range(span - 1) - (span >> 1));
	endfunction

	// Run the separating-axis test over both edge axes of each box and advance the
	// contact bit. No normalisation: both sides carry the same 2*|axis| factor.
	function automatic contact_outcome_t step_contact(pair_beat_t b);
		logic signed [63:0] ex[4];
		logic signed [63:0] ey[4];
		logic signed [63:0] cx;
		logic signed [63:0] cy;
		logic signed [63:0] d;
		logic signed [63:0] span;
		logic signed [63:0] reach;
		contact_outcome_t   o;
		bit                 prev;
		o.hit = 1'b1;
		cx = b.cx;
		cy = b.cy;
		for (int k = 0; k < 4; k++) begin
			ex[k] = b.edge_c[2 * k];
			ey[k] = b.edge_c[2 * k + 1];
		end
		for (int i = 0; i < 4; i++) begin
			span = 0;
			for (int j = 0; j < 4; j++) begin
				d = ex[i] * ex[j] + ey[i] * ey[j];
				span += (d < 0) ? -d : d;
			end
			reach = cx * ex[i] + cy * ey[i];
			if (reach < 0)
				reach = -reach;
			// a zero axis gives 0 > 0 here and never separates
			if (2 * reach > span)
				o.hit = 1'b0;
		end
		prev = contact_map[b.idx];
		if (o.hit) begin
			o.ev = b.dead ? EV_END : (prev ? EV_STAY : EV_BEGIN);
			contact_map[b.idx] = 1'b1;
		end else begin
			o.ev = prev ? EV_END : EV_NONE;
			contact_map[b.idx] = 1'b0;
		end
		return o;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
		mismatches++;
	endtask

	// Present one pair beat from a falling edge, with random idle cycles in
	// front, and return on the falling edge after it has been taken.
	task automatic send_pair(pair_beat_t b, bit typed, contact_outcome_t typed_out);
		while ($urandom_range(99) < src_idle_pct) begin
			pair_ch.valid <= 1'b0;
			@(negedge clk);
		end
		typed_pending = typed;
		typed_result  = typed_out;
		pair_ch.valid          <= 1'b1;
		pair_ch.pair_index     <= b.idx;
		pair_ch.either_dead    <= b.dead;
		pair_ch.left_edge_a_x  <= b.edge_c[0];
		pair_ch.left_edge_a_y  <= b.edge_c[1];
		pair_ch.left_edge_b_x  <= b.edge_c[2];
		pair_ch.left_edge_b_y  <= b.edge_c[3];
		pair_ch.right_edge_a_x <= b.edge_c[4];
		pair_ch.right_edge_a_y <= b.edge_c[5];
		pair_ch.right_edge_b_x <= b.edge_c[6];
		pair_ch.right_edge_b_y <= b.edge_c[7];
		pair_ch.centre_delta_x <= b.cx;
		pair_ch.centre_delta_y <= b.cy;
		do
			@(posedge clk);
		while (!pair_ch.ready);
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result has been taken
	task automatic drain_results();
		pair_ch.valid <= 1'b0;
		while (awaited_events.size() != 0)
			@(negedge clk);
	endtask

	// Result receiver: stall at random, rate set per phase
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Scoreboard. Check the result beat first, then queue the prediction for
	// a pair beat taken at the same edge; it cannot be due before it has passed the pipeline.
	always @(posedge clk) begin
		pair_beat_t       seen;
		contact_outcome_t want;
		contact_outcome_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_events.size() == 0) begin
				flag_mismatch("result beat with nothing awaited, event",
					result_ch.contact_event, 0);
			end else begin
				want = awaited_events.pop_front();
				if (result_ch.contact_event !== want.ev)
					flag_mismatch("contact_event", result_ch.contact_event, want.ev);
				if (result_ch.boxes_intersect !== want.hit)
					flag_mismatch("boxes_intersect", result_ch.boxes_intersect, want.hit);
			end
		end
		if (arst_n && pair_ch.valid && pair_ch.ready) begin
			seen.idx       = pair_ch.pair_index;
			seen.dead      = pair_ch.either_dead;
			seen.edge_c[0] = pair_ch.left_edge_a_x;
			seen.edge_c[1] = pair_ch.left_edge_a_y;
			seen.edge_c[2] = pair_ch.left_edge_b_x;
			seen.edge_c[3] = pair_ch.left_edge_b_y;
			seen.edge_c[4] = pair_ch.right_edge_a_x;
			seen.edge_c[5] = pair_ch.right_edge_a_y;
			seen.edge_c[6] = pair_ch.right_edge_b_x;
			seen.edge_c[7] = pair_ch.right_edge_b_y;
			seen.cx        = pair_ch.centre_delta_x;
			seen.cy        = pair_ch.centre_delta_y;
			// always advance the bitmap; a typed row overrides the expectation
			got = step_contact(seen);
			awaited_events.push_back(typed_pending ? typed_result : got);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, awaited_events.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		pair_beat_t       b;
		contact_outcome_t t;
		logic [11:0]      idx_pool [POOL_SIZE];
		int unsigned      scale;
		int unsigned      cscale;
		int unsigned      kind;

		// Drive every input to a known value before the first edge
		arst_n                 = 1'b0;
		pair_ch.valid          = 1'b0;
		pair_ch.pair_index     = '0;
		pair_ch.either_dead    = 1'b0;
		pair_ch.left_edge_a_x  = '0;
		pair_ch.left_edge_a_y  = '0;
		pair_ch.left_edge_b_x  = '0;
		pair_ch.left_edge_b_y  = '0;
		pair_ch.right_edge_a_x = '0;
		pair_ch.right_edge_a_y = '0;
		pair_ch.right_edge_b_x = '0;
		pair_ch.right_edge_b_y = '0;
		pair_ch.centre_delta_x = '0;
		pair_ch.centre_delta_y = '0;
		typed_pending          = 1'b0;
		typed_result.ev        = EV_NONE;
		typed_result.hit       = 1'b0;
		src_idle_pct           = 14;
		snk_idle_pct           = 50;
		mismatches             = 0;
		cycles                 = 0;
		for (int k = 0; k < 4096; k++)
			contact_map[k] = 1'b0;

		// Hold reset, then release on a falling edge. The block
		// then sweeps its bitmap with ready low; the handshake absorbs that.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: walk the table
		for (int r = 0; r < DIR_ROWS; r++) begin
			b.idx  = 12'(PAIR_TABLE[r][0]);
			b.dead = PAIR_TABLE[r][1][0];
			for (int k = 0; k < 8; k++)
				b.edge_c[k] = 16'(PAIR_TABLE[r][2 + k]);
			b.cx  = 16'(PAIR_TABLE[r][10]);
			b.cy  = 16'(PAIR_TABLE[r][11]);
			t.ev  = contact_event_t'(PAIR_TABLE[r][13]);
			t.hit = PAIR_TABLE[r][14][0];
			send_pair(b, PAIR_TABLE[r][12] != 0, t);
		end
		typed_pending = 1'b0;
		drain_results();

		// A small pool of pairs so that contacts begin, continue and end
		for (int k = 0; k < POOL_SIZE; k++)
			idx_pool[k] = 12'($urandom_range(4095));

		// Random part, three idle profiles: slow receiver, slow sender, none
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
			snk_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 14 : 0;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				kind = $urandom_range(9);
				if (kind == 0) begin
					// noise: full-range fields, any pair
					b.idx  = 12'($urandom_range(4095));
					b.dead = 1'($urandom_range(1));
					for (int k = 0; k < 8; k++)
						b.edge_c[k] = rand_coord(15);
					b.cx = rand_coord(15);
					b.cy = rand_coord(15);
				end else begin
					// plausible boxes with the centre gap on the same scale,
					// so hits and misses come in similar numbers
					b.idx = ($urandom_range(7) == 0) ? 12'($urandom_range(4095))
						: idx_pool[$urandom_range(POOL_SIZE - 1)];
					b.dead = ($urandom_range(7) == 0);
					scale  = $urandom_range(3, 13);
					cscale = scale + $urandom_range(0, 2);
					for (int k = 0; k < 8; k++)
						b.edge_c[k] = rand_coord(scale);
					// now and then collapse one edge to a point
					if ($urandom_range(15) == 0) begin
						kind = $urandom_range(3);
						b.edge_c[2 * kind]     = '0;
						b.edge_c[2 * kind + 1] = '0;
					end
					b.cx = rand_coord(cscale);
					b.cy = rand_coord(cscale);
				end
				send_pair(b, 1'b0, t);
			end
			// let the pipeline run dry between profiles
			drain_results();
		end

		// Wind down: nothing left awaited, then let the pipeline settle
		drain_results();
		repeat (PIPE_DRAIN) @(negedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
